FILE: sv/sca_pkg.sv
package sca_pkg;

  typedef struct packed {
    logic ext;
    logic meta;
    logic caps;
    logic shift;
    logic ctl;
  } flags_t;

  localparam logic [7:0] SC_RELEASE = 8'h80;
  localparam logic [7:0] SC_LSHIFT  = 8'h2a;
  localparam logic [7:0] SC_RSHIFT  = 8'h36;
  localparam logic [7:0] SC_LMETA   = 8'h38;
  localparam logic [7:0] SC_LCTL    = 8'h1d;
  localparam logic [7:0] SC_CAPS    = 8'h3a;
  localparam logic [7:0] SC_PREFIX  = 8'he0;
  localparam logic [7:0] META_BIT   = 8'h80;

  localparam int PLAIN_LEN = 58;
  localparam int CTL_LEN   = 51;

  localparam logic [7:0] PLAIN_TAB [PLAIN_LEN] = '{
    8'h00,
    8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
    8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61,
    8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b, 8'h27,
    8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h6d,
    8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h20
  };

  localparam logic [7:0] UPPER_TAB [PLAIN_LEN] = '{
    8'h00,
    8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28,
    8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
    8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41,
    8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a, 8'h22,
    8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d,
    8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h00, 8'h00, 8'h20
  };

  localparam logic [7:0] CTL_TAB [CTL_LEN] = '{
    8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h1f, 8'h00, 8'h08, 8'h09, 8'h11, 8'h17, 8'h05, 8'h12, 8'h14,
    8'h19, 8'h15, 8'h09, 8'h0f, 8'h10, 8'h1b, 8'h1d, 8'h0a, 8'h00, 8'h01,
    8'h13, 8'h04, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0c, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h1c, 8'h1a, 8'h18, 8'h03, 8'h16, 8'h02, 8'h0e, 8'h0d
  };

  function automatic flags_t modifier_bit(input logic [7:0] key);
    flags_t f;
    f = '0;
    if (key == SC_LSHIFT || key == SC_RSHIFT) f.shift = 1'b1;
    if (key == SC_CAPS) f.caps = 1'b1;
    if (key == SC_LCTL) f.ctl = 1'b1;
    if (key == SC_LMETA) f.meta = 1'b1;
    return f;
  endfunction

endpackage

FILE: sv/sca_translate.sv
module sca_translate (
  input  logic [7:0]      code,
  input  sca_pkg::flags_t flags,
  output sca_pkg::flags_t flags_next,
  output logic            has_char,
  output logic [7:0]      char_code
);

  sca_pkg::flags_t bit_make;
  sca_pkg::flags_t bit_break;
  logic [7:0]      tab_char;
  logic [5:0]      idx;
  logic            use_upper;

  assign idx       = code[5:0];
  assign bit_make  = sca_pkg::modifier_bit(code);
  assign bit_break = sca_pkg::modifier_bit({1'b0, code[6:0]});
  assign use_upper = flags.shift ^ flags.caps;

  always_comb begin
    tab_char = 8'h00;
    if (flags.ctl) begin
      if ({2'b00, code} < 10'(sca_pkg::CTL_LEN)) begin
        tab_char = sca_pkg::CTL_TAB[idx];
      end
    end else if ({2'b00, code} < 10'(sca_pkg::PLAIN_LEN)) begin
      tab_char = use_upper ? sca_pkg::UPPER_TAB[idx] : sca_pkg::PLAIN_TAB[idx];
    end
  end

  always_comb begin
    flags_next = flags;
    char_code  = 8'h00;
    if (flags.ext) begin
      flags_next.ext = 1'b0;
    end else if (code == sca_pkg::SC_PREFIX) begin
      flags_next.ext = 1'b1;
    end else if ((code & sca_pkg::SC_RELEASE) != 8'h00) begin
      flags_next = sca_pkg::flags_t'(flags & ~bit_break);
    end else if (bit_make != '0) begin
      flags_next = sca_pkg::flags_t'(flags | bit_make);
    end else if (tab_char != 8'h00) begin
      char_code = flags.meta ? (tab_char | sca_pkg::META_BIT) : tab_char;
    end
  end

  assign has_char = (char_code != 8'h00);

endmodule

FILE: sv/scan_code_to_ascii.sv
// Translates PC set-1 keyboard scan codes into characters.
// The input channel (in_valid, in_ready, scan_code) takes one raw scan byte
// per item. The output channel (out_valid, out_ready, has_char, char_code)
// returns exactly one item per input item, in order. has_char is 1 when the
// byte produced a character and char_code then holds it, with bit 7 set when
// meta is held; otherwise char_code is 0.
// An accepted byte is held in an input register, where the table lookup and
// the modifier update are done, and its result is then registered in the
// output register, which raises out_valid; the byte moves on once the output
// register is empty or is being taken. With out_ready held high
// the block takes one item every cycle.
// When the receiver stalls, the result stays in the output register and one
// more byte can wait in the input register; in_ready then drops until the
// output is taken.
// Reset empties both registers and clears all modifier flags (shift, caps
// lock, control, meta and the extended-prefix mark).
module scan_code_to_ascii (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       has_char,
  output logic [7:0] char_code
);

  logic            stage_valid;
  logic [7:0]      stage_code;
  logic            stage_move;
  sca_pkg::flags_t flags;
  sca_pkg::flags_t flags_next;
  logic            has_char_next;
  logic [7:0]      char_code_next;

  assign stage_move = stage_valid && (!out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_move;

  sca_translate u_translate (
    .code       (stage_code),
    .flags      (flags),
    .flags_next (flags_next),
    .has_char   (has_char_next),
    .char_code  (char_code_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      flags       <= '0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (stage_move) begin
        out_valid <= 1'b1;
        flags     <= flags_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_code <= scan_code;
    end
    if (stage_move) begin
      has_char  <= has_char_next;
      char_code <= char_code_next;
    end
  end

endmodule
